// File: sv/ppg_pkg.sv
// Shared types, constants and codes of the pulse-oximeter sample processor.
package ppg_pkg;

  localparam int SampleBits     = 18;
  localparam int ProdBits       = 2 * SampleBits;
  localparam int DivBits        = 32;
  localparam int AddrBits       = 5;
  localparam int DefWindowDepth = 60;
  localparam int DefRateDepth   = 8;

  localparam logic [17:0] FingerLevelRst = 18'd30000;
  localparam logic [15:0] BeatLevelRst   = 16'd200;
  localparam logic [17:0] MinSwingRst    = 18'd50;
  localparam logic [5:0]  MinFillRst     = 6'd20;
  localparam logic [15:0] HpAlphaRst     = 16'd62259;
  localparam logic [15:0] MinGapRst      = 16'd300;
  localparam logic [15:0] MaxGapRst      = 16'd1500;

  localparam logic [39:0] HpLimit     = 40'h7F_FFFF_FFFF;
  localparam logic [21:0] CoefSq      = 22'd2953052;
  localparam logic [20:0] CoefLin     = 21'd1989279;
  localparam logic [22:0] CoefZero    = 23'd6215761;
  localparam logic [15:0] KeepWeight  = 16'd58982;
  localparam logic [12:0] NewWeight   = 13'd6554;
  localparam logic [18:0] RatioClip   = 19'd262144;
  localparam logic [15:0] MsPerMinute = 16'd60000;
  localparam logic [11:0] Spo2Min     = 12'd80;
  localparam logic [11:0] Spo2Max     = 12'd100;

  typedef enum logic [2:0] {
    REG_FINGER_LEVEL,
    REG_BEAT_LEVEL,
    REG_MIN_IR_SWING,
    REG_MIN_FILL,
    REG_HP_ALPHA,
    REG_MIN_GAP,
    REG_MAX_GAP
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_RATE,
    DIV_AVG,
    DIV_RATIO
  } div_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CLEAR,
    S_HP_ABS,
    S_HP_MUL,
    S_BEAT,
    S_RATE_DIV,
    S_RATE_PUSH,
    S_RATE_SUM,
    S_AVG_GO,
    S_AVG_DIV,
    S_AVG_SET,
    S_WIN_WR,
    S_FILL,
    S_SCAN,
    S_SCAN_TAIL,
    S_SWING,
    S_PRODUCTS,
    S_RATIO_GO,
    S_RATIO_DIV,
    S_POLY1,
    S_POLY2,
    S_POLY3,
    S_SMOOTH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [17:0] finger_level;
    logic [15:0] beat_level;
    logic [17:0] min_ir_swing;
    logic [5:0]  min_fill;
    logic [15:0] hp_alpha;
    logic [15:0] min_gap;
    logic [15:0] max_gap;
  } cfg_t;

  typedef struct packed {
    logic     load;
    logic     clear;
    logic     hp_abs;
    logic     hp_mul;
    logic     beat;
    logic     div_start;
    div_sel_e div_sel;
    logic     rate_push;
    logic     sum_start;
    logic     sum_step;
    logic     avg_set;
    logic     win_wr;
    logic     scan_start;
    logic     scan_step;
    logic     swing;
    logic     products;
    logic     ratio_set;
    logic     poly1;
    logic     poly2;
    logic     poly3;
    logic     smooth;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic finger_ok;
    logic beat_rate;
    logic div_busy;
    logic sum_last;
    logic fill_ok;
    logic scan_last;
    logic spo2_ok;
    logic ratio_sat;
  } sts_t;

endpackage

// File: sv/ppg_regs.sv
// Configuration register file behind the APB-style port.
module ppg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppg_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output ppg_pkg::cfg_t                  cfg_o
);
  import ppg_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrBits-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FINGER_LEVEL: cfg_d.finger_level = pwdata[17:0];
        REG_BEAT_LEVEL:   cfg_d.beat_level   = pwdata[15:0];
        REG_MIN_IR_SWING: cfg_d.min_ir_swing = pwdata[17:0];
        REG_MIN_FILL:     cfg_d.min_fill     = pwdata[5:0];
        REG_HP_ALPHA:     cfg_d.hp_alpha     = pwdata[15:0];
        REG_MIN_GAP:      cfg_d.min_gap      = pwdata[15:0];
        REG_MAX_GAP:      cfg_d.max_gap      = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FINGER_LEVEL: prdata = 32'(cfg_q.finger_level);
      REG_BEAT_LEVEL:   prdata = 32'(cfg_q.beat_level);
      REG_MIN_IR_SWING: prdata = 32'(cfg_q.min_ir_swing);
      REG_MIN_FILL:     prdata = 32'(cfg_q.min_fill);
      REG_HP_ALPHA:     prdata = 32'(cfg_q.hp_alpha);
      REG_MIN_GAP:      prdata = 32'(cfg_q.min_gap);
      REG_MAX_GAP:      prdata = 32'(cfg_q.max_gap);
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.finger_level <= FingerLevelRst;
      cfg_q.beat_level   <= BeatLevelRst;
      cfg_q.min_ir_swing <= MinSwingRst;
      cfg_q.min_fill     <= MinFillRst;
      cfg_q.hp_alpha     <= HpAlphaRst;
      cfg_q.min_gap      <= MinGapRst;
      cfg_q.max_gap      <= MaxGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: sv/ppg_div.sv
// Restoring shift-subtract divider, one quotient bit per cycle.
module ppg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppg_pkg::DivBits-1:0]   dividend_i,
  input  logic [ppg_pkg::ProdBits-1:0]  divisor_i,
  input  logic [ppg_pkg::ProdBits-1:0]  rem_i,
  output logic                          busy_o,
  output logic [ppg_pkg::DivBits-1:0]   quotient_o
);
  import ppg_pkg::*;

  localparam int CntBits = $clog2(DivBits);

  logic                busy_q, busy_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [ProdBits-1:0] rem_q, div_q;
  logic [DivBits-1:0]  quo_q;
  logic [ProdBits:0]   trial;
  logic                fits;

  assign trial      = {rem_q, quo_q[DivBits-1]};
  assign fits       = trial >= {1'b0, div_q};
  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(DivBits - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? ProdBits'(trial - {1'b0, div_q}) : trial[ProdBits-1:0];
      quo_q <= {quo_q[DivBits-2:0], fits};
    end
  end

`ifndef SYNTH
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_runs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == CntBits'(DivBits - 1))
    else $error("divider did not start a full run");
  a_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && cnt_q == '0 && !start_i |=> !busy_q)
    else $error("divider overran its last step");
`endif

endmodule

// File: sv/ppg_ctrl.sv
// Sequencer that steps the datapath through one sample word.
module ppg_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  ppg_pkg::sts_t sts_i,
  output ppg_pkg::cmd_t cmd_o
);
  import ppg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  cmd_t   cmd;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    cmd.div_sel = DIV_RATE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = sts_i.finger_ok ? S_HP_ABS : S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        state_d   = S_OUT;
      end
      S_HP_ABS: begin
        cmd.hp_abs = 1'b1;
        state_d    = S_HP_MUL;
      end
      S_HP_MUL: begin
        cmd.hp_mul = 1'b1;
        state_d    = S_BEAT;
      end
      S_BEAT: begin
        cmd.beat = 1'b1;
        if (sts_i.beat_rate) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATE;
          state_d       = S_RATE_DIV;
        end else begin
          state_d = S_WIN_WR;
        end
      end
      S_RATE_DIV: begin
        if (!sts_i.div_busy) state_d = S_RATE_PUSH;
      end
      S_RATE_PUSH: begin
        cmd.rate_push = 1'b1;
        cmd.sum_start = 1'b1;
        state_d       = S_RATE_SUM;
      end
      S_RATE_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts_i.sum_last) state_d = S_AVG_GO;
      end
      S_AVG_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_AVG;
        state_d       = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (!sts_i.div_busy) state_d = S_AVG_SET;
      end
      S_AVG_SET: begin
        cmd.avg_set = 1'b1;
        state_d     = S_WIN_WR;
      end
      S_WIN_WR: begin
        cmd.win_wr = 1'b1;
        state_d    = S_FILL;
      end
      S_FILL: begin
        if (sts_i.fill_ok) begin
          cmd.scan_start = 1'b1;
          state_d        = S_SCAN;
        end else begin
          state_d = S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts_i.scan_last) state_d = S_SCAN_TAIL;
      end
      S_SCAN_TAIL: begin
        state_d = S_SWING;
      end
      S_SWING: begin
        cmd.swing = 1'b1;
        state_d   = S_PRODUCTS;
      end
      S_PRODUCTS: begin
        if (sts_i.spo2_ok) begin
          cmd.products = 1'b1;
          state_d      = S_RATIO_GO;
        end else begin
          state_d = S_OUT;
        end
      end
      S_RATIO_GO: begin
        if (sts_i.ratio_sat) begin
          cmd.ratio_set = 1'b1;
          state_d       = S_POLY1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_RATIO;
          state_d       = S_RATIO_DIV;
        end
      end
      S_RATIO_DIV: begin
        cmd.div_sel = DIV_RATIO;
        if (!sts_i.div_busy) begin
          cmd.ratio_set = 1'b1;
          state_d       = S_POLY1;
        end
      end
      S_POLY1: begin
        cmd.poly1 = 1'b1;
        state_d   = S_POLY2;
      end
      S_POLY2: begin
        cmd.poly2 = 1'b1;
        state_d   = S_POLY3;
      end
      S_POLY3: begin
        cmd.poly3 = 1'b1;
        state_d   = S_SMOOTH;
      end
      S_SMOOTH: begin
        cmd.smooth = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> out_free)
    else $error("result word overwritten before it was taken");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while one is in flight");
  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !sts_i.div_busy)
    else $error("division started while divider busy");
`endif

endmodule

// File: sv/ppg_dp.sv
// Datapath: filter, beat timing, rate history, sample window and SpO2 math.
module ppg_dp #(
  parameter int WindowDepth = ppg_pkg::DefWindowDepth,
  parameter int RateDepth   = ppg_pkg::DefRateDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ppg_pkg::cfg_t                   cfg_i,
  input  ppg_pkg::cmd_t                   cmd_i,
  output ppg_pkg::sts_t                   sts_o,
  input  logic [ppg_pkg::SampleBits-1:0]  red_sample_i,
  input  logic [ppg_pkg::SampleBits-1:0]  ir_sample_i,
  input  logic [31:0]                     time_ms_i,
  output logic                            finger_present_o,
  output logic [7:0]                      heart_rate_o,
  output logic [6:0]                      sat_pct_o,
  output logic                            spo2_valid_o,
  output logic [31:0]                     ratio_q16_o,
  output logic [31:0]                     sample_total_o
);
  import ppg_pkg::*;

  localparam int WinPosBits   = $clog2(WindowDepth);
  localparam int WinFillBits  = $clog2(WindowDepth + 1);
  localparam int RatePosBits  = (RateDepth > 1) ? $clog2(RateDepth) : 1;
  localparam int RateFillBits = $clog2(RateDepth + 1);
  localparam int SumBits      = 8 + RateFillBits;
  localparam logic [WinPosBits-1:0]   WinLast  = WinPosBits'(WindowDepth - 1);
  localparam logic [WinFillBits-1:0]  WinFull  = WinFillBits'(WindowDepth);
  localparam logic [RatePosBits-1:0]  RateLast = RatePosBits'(RateDepth - 1);
  localparam logic [RateFillBits-1:0] RateFull = RateFillBits'(RateDepth);

  // inputs and counter
  logic [SampleBits-1:0] red_q, ir_q;
  logic [31:0]           time_q;
  logic [31:0]           sample_cnt_q;

  // running state
  logic signed [39:0]     hp_q;
  logic [SampleBits-1:0]  prev_ir_q;
  logic                   went_neg_q;
  logic [31:0]            last_beat_q;
  logic [RatePosBits-1:0] rate_pos_q;
  logic [RateFillBits-1:0] rate_fill_q;
  logic [WinPosBits-1:0]  win_pos_q;
  logic [WinFillBits-1:0] win_fill_q;
  logic [23:0]            avg_q;
  logic [7:0]             rate_res_q;
  logic [6:0]             spo2_res_q;
  logic [31:0]            ratio_val_q;
  logic                   spo2_flag_q;
  logic                   finger_flag_q;

  // scratch
  logic [39:0]            hp_mag_q;
  logic                   hp_neg_q;
  logic [7:0]             rate_hist_q [RateDepth];
  logic [RatePosBits-1:0] sum_idx_q;
  logic [SumBits-1:0]     sum_q;
  logic [2*SampleBits-1:0] win_mem [WindowDepth];
  logic [2*SampleBits-1:0] rd_q;
  logic                   rd_vld_q;
  logic [WinPosBits-1:0]  scan_idx_q;
  logic                   scan_first_q;
  logic [SampleBits-1:0]  imin_q, imax_q, rmin_q, rmax_q;
  logic [SampleBits-1:0]  idc_q, rdc_q, iac_q, rac_q;
  logic [ProdBits-1:0]    p_q, d_q;
  logic [31:0]            ratio_q;
  logic [37:0]            r2_q;
  logic [39:0]            lin_q;
  logic [59:0]            neg_q, pos_q;
  logic [6:0]             spo2_q;

  // combinational
  logic signed [18:0]     ir_diff;
  logic signed [40:0]     hp_x;
  logic [55:0]            hp_prod;
  logic [39:0]            hp_m;
  logic                   beat_hit;
  logic [31:0]            gap;
  logic                   gap_ok;
  logic [DivBits-1:0]     div_dividend, div_quo;
  logic [ProdBits-1:0]    div_divisor, div_rem;
  logic                   div_busy;
  logic [5:0]             need;
  logic [SampleBits-1:0]  rd_ir, rd_red;
  logic [SampleBits:0]    isum, rsum;
  logic [18:0]            r_clip;
  logic [59:0]            poly_diff;
  logic [11:0]            v;
  logic [39:0]            keep_p;
  logic [19:0]            new_p;
  logic [40:0]            smooth_tot;
  logic [23:0]            avg_next;

  assign ir_diff  = signed'({1'b0, ir_q}) - signed'({1'b0, prev_ir_q});
  assign hp_x     = 41'(hp_q) + (41'(ir_diff) <<< 8);
  assign hp_prod  = hp_mag_q * cfg_i.hp_alpha;
  assign hp_m     = (hp_prod[55:16] > HpLimit) ? HpLimit : hp_prod[55:16];
  assign beat_hit = (hp_q > signed'({8'd0, cfg_i.beat_level, 8'd0})) && went_neg_q;
  assign gap      = time_q - last_beat_q;
  assign gap_ok   = (gap != 32'd0) && (gap >= {16'd0, cfg_i.min_gap})
                    && (gap <= {16'd0, cfg_i.max_gap});
  assign need     = (cfg_i.min_fill == 6'd0) ? 6'd1 : cfg_i.min_fill;
  assign rd_ir    = rd_q[SampleBits-1:0];
  assign rd_red   = rd_q[2*SampleBits-1:SampleBits];
  assign isum     = {1'b0, imax_q} + {1'b0, imin_q};
  assign rsum     = {1'b0, rmax_q} + {1'b0, rmin_q};
  assign r_clip   = (ratio_q > 32'(RatioClip)) ? RatioClip : ratio_q[18:0];
  assign poly_diff = pos_q - neg_q;
  assign v        = (neg_q >= pos_q) ? 12'd0 : poly_diff[59:48];
  assign keep_p   = KeepWeight * avg_q;
  assign new_p    = NewWeight * spo2_q;
  assign smooth_tot = 41'(keep_p) + 41'({new_p, 16'd0});
  assign avg_next = (avg_q == 24'd0) ? {1'b0, spo2_q, 16'd0} : smooth_tot[39:16];

  assign sts_o.finger_ok = ir_sample_i >= cfg_i.finger_level;
  assign sts_o.beat_rate = beat_hit && gap_ok;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.sum_last  = sum_idx_q == RateLast;
  assign sts_o.fill_ok   = 8'(win_fill_q) >= 8'(need);
  assign sts_o.scan_last = WinFillBits'(scan_idx_q) == win_fill_q - 1'b1;
  assign sts_o.spo2_ok   = (idc_q != '0) && (rdc_q != '0) && (iac_q > cfg_i.min_ir_swing);
  assign sts_o.ratio_sat = {16'd0, p_q} >= {d_q, 16'd0};

  always_comb begin
    case (cmd_i.div_sel)
      DIV_RATE: begin
        div_dividend = {16'd0, MsPerMinute};
        div_divisor  = ProdBits'(gap[15:0]);
        div_rem      = '0;
      end
      DIV_AVG: begin
        div_dividend = DivBits'(sum_q);
        div_divisor  = ProdBits'(rate_fill_q);
        div_rem      = '0;
      end
      DIV_RATIO: begin
        div_dividend = {p_q[15:0], 16'd0};
        div_divisor  = d_q;
        div_rem      = ProdBits'(p_q[ProdBits-1:16]);
      end
      default: begin
        div_dividend = '0;
        div_divisor  = '0;
        div_rem      = '0;
      end
    endcase
  end

  ppg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .rem_i      (div_rem),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_cnt_q  <= '0;
      hp_q          <= '0;
      prev_ir_q     <= '0;
      went_neg_q    <= 1'b1;
      last_beat_q   <= '0;
      rate_pos_q    <= '0;
      rate_fill_q   <= '0;
      win_pos_q     <= '0;
      win_fill_q    <= '0;
      avg_q         <= '0;
      rate_res_q    <= '0;
      spo2_res_q    <= '0;
      ratio_val_q   <= '0;
      spo2_flag_q   <= 1'b0;
      finger_flag_q <= 1'b0;
      rd_vld_q      <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_step;
      if (cmd_i.load) begin
        sample_cnt_q  <= sample_cnt_q + 1'b1;
        finger_flag_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        hp_q          <= '0;
        prev_ir_q     <= '0;
        went_neg_q    <= 1'b1;
        last_beat_q   <= '0;
        rate_pos_q    <= '0;
        rate_fill_q   <= '0;
        win_pos_q     <= '0;
        win_fill_q    <= '0;
        avg_q         <= '0;
        rate_res_q    <= '0;
        spo2_res_q    <= '0;
        ratio_val_q   <= '0;
        spo2_flag_q   <= 1'b0;
        finger_flag_q <= 1'b0;
      end
      if (cmd_i.hp_mul) begin
        hp_q      <= hp_neg_q ? -signed'(hp_m) : signed'(hp_m);
        prev_ir_q <= ir_q;
      end
      if (cmd_i.beat) begin
        if (beat_hit) begin
          went_neg_q  <= 1'b0;
          last_beat_q <= time_q;
        end else if (hp_q < 0) begin
          went_neg_q <= 1'b1;
        end
      end
      if (cmd_i.rate_push) begin
        rate_pos_q <= (rate_pos_q == RateLast) ? '0 : rate_pos_q + 1'b1;
        if (rate_fill_q < RateFull) rate_fill_q <= rate_fill_q + 1'b1;
      end
      if (cmd_i.avg_set) rate_res_q <= div_quo[7:0];
      if (cmd_i.win_wr) begin
        win_pos_q <= (win_pos_q == WinLast) ? '0 : win_pos_q + 1'b1;
        if (win_fill_q < WinFull) win_fill_q <= win_fill_q + 1'b1;
      end
      if (cmd_i.smooth) begin
        avg_q       <= avg_next;
        spo2_res_q  <= avg_next[22:16];
        ratio_val_q <= ratio_q;
        spo2_flag_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q  <= red_sample_i;
      ir_q   <= ir_sample_i;
      time_q <= time_ms_i;
    end
    if (cmd_i.hp_abs) begin
      hp_neg_q <= hp_x[40];
      hp_mag_q <= hp_x[40] ? 40'(-hp_x) : 40'(hp_x);
    end
    if (cmd_i.rate_push) begin
      rate_hist_q[rate_pos_q] <= (div_quo > 32'd255) ? 8'hFF : div_quo[7:0];
    end
    if (cmd_i.sum_start) begin
      sum_q     <= '0;
      sum_idx_q <= '0;
    end else if (cmd_i.sum_step) begin
      if (RateFillBits'(sum_idx_q) < rate_fill_q) begin
        sum_q <= sum_q + SumBits'(rate_hist_q[sum_idx_q]);
      end
      sum_idx_q <= sum_idx_q + 1'b1;
    end
    if (cmd_i.win_wr) win_mem[win_pos_q] <= {red_q, ir_q};
    if (cmd_i.scan_start) begin
      scan_idx_q   <= '0;
      scan_first_q <= 1'b1;
    end else if (cmd_i.scan_step) begin
      rd_q       <= win_mem[scan_idx_q];
      scan_idx_q <= scan_idx_q + 1'b1;
    end
    if (rd_vld_q) begin
      scan_first_q <= 1'b0;
      if (scan_first_q) begin
        imin_q <= rd_ir;
        imax_q <= rd_ir;
        rmin_q <= rd_red;
        rmax_q <= rd_red;
      end else begin
        if (rd_ir < imin_q)  imin_q <= rd_ir;
        if (rd_ir > imax_q)  imax_q <= rd_ir;
        if (rd_red < rmin_q) rmin_q <= rd_red;
        if (rd_red > rmax_q) rmax_q <= rd_red;
      end
    end
    if (cmd_i.swing) begin
      idc_q <= isum[SampleBits:1];
      rdc_q <= rsum[SampleBits:1];
      iac_q <= imax_q - imin_q;
      rac_q <= rmax_q - rmin_q;
    end
    if (cmd_i.products) begin
      p_q <= rac_q * idc_q;
      d_q <= rdc_q * iac_q;
    end
    if (cmd_i.ratio_set) ratio_q <= sts_o.ratio_sat ? 32'hFFFF_FFFF : div_quo;
    if (cmd_i.poly1) begin
      r2_q  <= r_clip * r_clip;
      lin_q <= r_clip * CoefLin;
    end
    if (cmd_i.poly2) begin
      neg_q <= r2_q * CoefSq;
      pos_q <= 60'({lin_q, 16'd0}) + {5'd0, CoefZero, 32'd0};
    end
    if (cmd_i.poly3) begin
      if (v < Spo2Min) begin
        spo2_q <= Spo2Min[6:0];
      end else if (v > Spo2Max) begin
        spo2_q <= Spo2Max[6:0];
      end else begin
        spo2_q <= v[6:0];
      end
    end
    if (cmd_i.out_load) begin
      finger_present_o <= finger_flag_q;
      heart_rate_o     <= rate_res_q;
      sat_pct_o        <= spo2_res_q;
      spo2_valid_o     <= spo2_flag_q;
      ratio_q16_o      <= ratio_val_q;
      sample_total_o   <= sample_cnt_q;
    end
  end

endmodule

// File: sv/pulse_oximeter_sample_processor.sv
// Flow: a word without a finger clears state and goes to the result word; a rate update
// adds two divides and RateDepth sums, an SpO2 pass a scan over the filled window.
// Throughput: one word at a time, the next taken in the cycle after the result loads;
// the divider and the one-read-per-cycle scan set it.
// Reset: asynchronous active low; registers return to defaults, state clears,
// window and rate memories need no clearing and are read only once written.
module pulse_oximeter_sample_processor #(
  parameter int WindowDepth = ppg_pkg::DefWindowDepth,
  parameter int RateDepth   = ppg_pkg::DefRateDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [ppg_pkg::SampleBits-1:0] red_sample_i,
  input  logic [ppg_pkg::SampleBits-1:0] ir_sample_i,
  input  logic [31:0]                    time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           finger_present_o,
  output logic [7:0]                     heart_rate_o,
  output logic [6:0]                     sat_pct_o,
  output logic                           spo2_valid_o,
  output logic [31:0]                    ratio_q16_o,
  output logic [31:0]                    sample_total_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ppg_pkg::AddrBits-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import ppg_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ppg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppg_dp #(
    .WindowDepth (WindowDepth),
    .RateDepth   (RateDepth)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .red_sample_i     (red_sample_i),
    .ir_sample_i      (ir_sample_i),
    .time_ms_i        (time_ms_i),
    .finger_present_o (finger_present_o),
    .heart_rate_o     (heart_rate_o),
    .sat_pct_o        (sat_pct_o),
    .spo2_valid_o     (spo2_valid_o),
    .ratio_q16_o      (ratio_q16_o),
    .sample_total_o   (sample_total_o)
  );

endmodule
